// ===== rtl/core/encoder_position_speed_defines.svh =====
// Assertion macros shared by the encoder position and speed block.
`ifndef ENCODER_POSITION_SPEED_DEFINES_SVH
`define ENCODER_POSITION_SPEED_DEFINES_SVH

// Check that a condition implies another in the same cycle.
`define EPS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("encoder_position_speed: same-cycle check failed");

// Check that a condition implies another in the following cycle.
`define EPS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("encoder_position_speed: next-cycle check failed");

`endif

// ===== rtl/core/eps_pkg.sv =====
// Shared types and constants for the encoder position and speed block.
package eps_pkg;

  // Field and register widths
  localparam int READ_W    = 16;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int TOTAL_W   = 32;
  localparam int POS_W     = 40;
  localparam int SPD_W     = 34;
  localparam int Q8_SHIFT  = 8;

  // Divider geometry: 40-bit dividend, 32-bit divisor, two quotient bits a cycle
  localparam int DVD_W      = 40;
  localparam int DSR_W      = 32;
  localparam int RADIX_BITS = 2;
  localparam int DIV_STEPS  = DVD_W / RADIX_BITS;
  localparam int STEP_CNT_W = $clog2(DIV_STEPS);

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PPM    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_PERIOD = 2'd1;

  // Register reset values
  localparam logic [CFG_W-1:0] PPM_RESET    = 16'd1;
  localparam logic [CFG_W-1:0] PERIOD_RESET = 16'd10;

  // Scaling constants: Q8 times 1000 ms per s, and the half-millimetre offset
  localparam logic [17:0]      SPD_SCALE  = 18'd256000;
  localparam logic [POS_W-1:0] POS_OFFSET = 40'd128;

  // Saturation limits of the pulse total
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = 32'h7FFF_FFFF;
  localparam logic [TOTAL_W-1:0] TOTAL_MIN = 32'h8000_0000;

  // Item as classified by the front: magnitudes and signs
  typedef struct packed {
    logic [TOTAL_W-1:0] tot_mag;
    logic               tot_neg;
    logic [READ_W-1:0]  dlt_mag;
    logic               dlt_neg;
    logic               sat;
  } q_entry_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_DIV_POS,
    BK_DIV_SPD,
    BK_FIN
  } bk_state_t;

endpackage

// ===== rtl/core/eps_front.sv =====
// Front end: accepts readings, keeps the saturating pulse total, classifies items.
module eps_front (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [eps_pkg::READ_W-1:0]  in_counter_reading,
  input  eps_pkg::q_status_t          q_status,
  output logic                        q_push,
  output eps_pkg::q_entry_t           q_wdata
);

  logic [eps_pkg::TOTAL_W-1:0] total_r;
  logic [eps_pkg::TOTAL_W-1:0] total_nxt;
  logic [eps_pkg::TOTAL_W:0]   sum;
  logic                        ovf;
  logic [eps_pkg::TOTAL_W-1:0] clamped;
  logic                        dlt_neg;

  // Stall while the queue has no room
  assign in_stall = q_status.full;
  assign q_push   = in_valid && !q_status.full;

  // Add the signed delta to the total and clamp on overflow
  always_comb begin
    dlt_neg = in_counter_reading[eps_pkg::READ_W-1];
    sum = {total_r[eps_pkg::TOTAL_W-1], total_r}
        + {{(eps_pkg::TOTAL_W + 1 - eps_pkg::READ_W){dlt_neg}}, in_counter_reading};
    ovf = sum[eps_pkg::TOTAL_W] ^ sum[eps_pkg::TOTAL_W-1];
    if (ovf) begin
      clamped = sum[eps_pkg::TOTAL_W] ? eps_pkg::TOTAL_MIN : eps_pkg::TOTAL_MAX;
    end else begin
      clamped = sum[eps_pkg::TOTAL_W-1:0];
    end
    total_nxt = q_push ? clamped : total_r;
  end

  // Split the new total and the delta into sign and magnitude
  always_comb begin
    q_wdata.tot_neg = clamped[eps_pkg::TOTAL_W-1];
    q_wdata.tot_mag = clamped[eps_pkg::TOTAL_W-1] ? (eps_pkg::TOTAL_W'(0) - clamped) : clamped;
    q_wdata.dlt_neg = dlt_neg;
    q_wdata.dlt_mag = dlt_neg ? (eps_pkg::READ_W'(0) - in_counter_reading)
                              : in_counter_reading;
    q_wdata.sat     = ovf;
  end

  // Pulse total register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else begin
      total_r <= total_nxt;
    end
  end

endmodule

// ===== rtl/core/eps_fifo.sv =====
// Short queue of classified items between front and back.
module eps_fifo #(
  parameter int DEPTH = eps_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  eps_pkg::q_entry_t  wdata,
  input  logic               pop,
  output eps_pkg::q_entry_t  rdata,
  output eps_pkg::q_status_t status
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  eps_pkg::q_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_nxt;
  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    r = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    return r;
  endfunction

  assign status.full  = (count_r == CNT_W'(DEPTH));
  assign status.empty = (count_r == '0);
  assign rdata        = mem_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    unique case ({push, pop})
      2'b10:   count_nxt = count_r + CNT_W'(1);
      2'b01:   count_nxt = count_r - CNT_W'(1);
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

// ===== rtl/core/eps_back.sv =====
// Back end: configuration registers, shared radix-4 divider and result register.
module eps_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eps_pkg::CFG_W-1:0]         cfg_wdata,
  input  eps_pkg::q_status_t                q_status,
  output logic                              q_pop,
  input  eps_pkg::q_entry_t                 q_rdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [eps_pkg::POS_W-1:0]  out_position_q8,
  output logic signed [eps_pkg::SPD_W-1:0]  out_speed_q8,
  output logic                              out_total_saturated
);

  localparam int DVD_W = eps_pkg::DVD_W;
  localparam int DSR_W = eps_pkg::DSR_W;
  localparam int CNT_W = eps_pkg::STEP_CNT_W;

  eps_pkg::bk_state_t state_r, state_nxt;

  logic [eps_pkg::CFG_W-1:0] ppm_r, ppm_nxt;
  logic [eps_pkg::CFG_W-1:0] per_r, per_nxt;
  logic [eps_pkg::CFG_W-1:0] ppm_eff;
  logic [eps_pkg::CFG_W-1:0] per_eff;

  eps_pkg::q_entry_t          ent_r, ent_nxt;
  logic [eps_pkg::SPD_W-1:0]  spd_dvd_r, spd_dvd_nxt;
  logic [DSR_W-1:0]           spd_dsr_r, spd_dsr_nxt;
  logic [DVD_W-1:0]           dvd_r, dvd_nxt;
  logic [DSR_W-1:0]           dsr_r, dsr_nxt;
  logic [DSR_W-1:0]           rem_r, rem_nxt;
  logic [CNT_W-1:0]           cnt_r, cnt_nxt;
  logic [eps_pkg::POS_W-1:0]  qpos_r, qpos_nxt;

  logic                       out_valid_r, out_valid_nxt;
  logic [eps_pkg::POS_W-1:0]  out_pos_r, out_pos_nxt;
  logic [eps_pkg::SPD_W-1:0]  out_spd_r, out_spd_nxt;
  logic                       out_sat_r, out_sat_nxt;

  logic [DVD_W-1:0]           dvd_w;
  logic [DSR_W-1:0]           rem_w;
  logic [eps_pkg::POS_W-1:0]  pos_res;
  logic [eps_pkg::SPD_W-1:0]  spd_res;

  assign out_valid           = out_valid_r;
  assign out_position_q8     = signed'(out_pos_r);
  assign out_speed_q8        = signed'(out_spd_r);
  assign out_total_saturated = out_sat_r;

  // Take zero settings as one
  assign ppm_eff = (ppm_r == '0) ? eps_pkg::CFG_W'(1) : ppm_r;
  assign per_eff = (per_r == '0) ? eps_pkg::CFG_W'(1) : per_r;

  // Write configuration; unknown indexes drop
  always_comb begin
    ppm_nxt = ppm_r;
    per_nxt = per_r;
    if (cfg_we) begin
      if (cfg_index == eps_pkg::CFG_IDX_PPM) begin
        ppm_nxt = cfg_wdata;
      end else if (cfg_index == eps_pkg::CFG_IDX_PERIOD) begin
        per_nxt = cfg_wdata;
      end
    end
  end

  // Two restoring division steps per cycle
  always_comb begin
    logic [DSR_W:0] trial;
    rem_w = rem_r;
    dvd_w = dvd_r;
    for (int i = 0; i < eps_pkg::RADIX_BITS; i++) begin
      trial = {rem_w, dvd_w[DVD_W-1]};
      dvd_w = {dvd_w[DVD_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr_r}) begin
        rem_w    = DSR_W'(trial - {1'b0, dsr_r});
        dvd_w[0] = 1'b1;
      end else begin
        rem_w = trial[DSR_W-1:0];
      end
    end
  end

  // Restore signs and add the half-millimetre offset
  always_comb begin
    pos_res = (ent_r.tot_neg ? (eps_pkg::POS_W'(0) - qpos_r) : qpos_r) + eps_pkg::POS_OFFSET;
    spd_res = ent_r.dlt_neg ? (eps_pkg::SPD_W'(0) - dvd_r[eps_pkg::SPD_W-1:0])
                            : dvd_r[eps_pkg::SPD_W-1:0];
  end

  // Sequencer: pop, scale, divide position, divide speed, hand off
  always_comb begin
    state_nxt     = state_r;
    q_pop         = 1'b0;
    ent_nxt       = ent_r;
    spd_dvd_nxt   = spd_dvd_r;
    spd_dsr_nxt   = spd_dsr_r;
    dvd_nxt       = dvd_r;
    dsr_nxt       = dsr_r;
    rem_nxt       = rem_r;
    cnt_nxt       = cnt_r;
    qpos_nxt      = qpos_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_pos_nxt   = out_pos_r;
    out_spd_nxt   = out_spd_r;
    out_sat_nxt   = out_sat_r;
    unique case (state_r)
      eps_pkg::BK_IDLE: begin
        if (!q_status.empty) begin
          q_pop     = 1'b1;
          ent_nxt   = q_rdata;
          state_nxt = eps_pkg::BK_MUL;
        end
      end
      eps_pkg::BK_MUL: begin
        spd_dsr_nxt = DSR_W'(ppm_eff) * DSR_W'(per_eff);
        spd_dvd_nxt = eps_pkg::SPD_W'(ent_r.dlt_mag) * eps_pkg::SPD_W'(eps_pkg::SPD_SCALE);
        dvd_nxt     = {ent_r.tot_mag, {eps_pkg::Q8_SHIFT{1'b0}}};
        dsr_nxt     = DSR_W'(ppm_eff);
        rem_nxt     = '0;
        cnt_nxt     = CNT_W'(eps_pkg::DIV_STEPS - 1);
        state_nxt   = eps_pkg::BK_DIV_POS;
      end
      eps_pkg::BK_DIV_POS: begin
        dvd_nxt = dvd_w;
        rem_nxt = rem_w;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          qpos_nxt  = dvd_w;
          dvd_nxt   = DVD_W'(spd_dvd_r);
          dsr_nxt   = spd_dsr_r;
          rem_nxt   = '0;
          cnt_nxt   = CNT_W'(eps_pkg::DIV_STEPS - 1);
          state_nxt = eps_pkg::BK_DIV_SPD;
        end
      end
      eps_pkg::BK_DIV_SPD: begin
        dvd_nxt = dvd_w;
        rem_nxt = rem_w;
        cnt_nxt = cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          state_nxt = eps_pkg::BK_FIN;
        end
      end
      eps_pkg::BK_FIN: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_pos_nxt   = pos_res;
          out_spd_nxt   = spd_res;
          out_sat_nxt   = ent_r.sat;
          state_nxt     = eps_pkg::BK_IDLE;
        end
      end
      default: begin
        state_nxt = eps_pkg::BK_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= eps_pkg::BK_IDLE;
      out_valid_r <= 1'b0;
      ppm_r       <= eps_pkg::PPM_RESET;
      per_r       <= eps_pkg::PERIOD_RESET;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ppm_r       <= ppm_nxt;
      per_r       <= per_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    ent_r     <= ent_nxt;
    spd_dvd_r <= spd_dvd_nxt;
    spd_dsr_r <= spd_dsr_nxt;
    dvd_r     <= dvd_nxt;
    dsr_r     <= dsr_nxt;
    rem_r     <= rem_nxt;
    cnt_r     <= cnt_nxt;
    qpos_r    <= qpos_nxt;
    out_pos_r <= out_pos_nxt;
    out_spd_r <= out_spd_nxt;
    out_sat_r <= out_sat_nxt;
  end

endmodule

// ===== rtl/core/encoder_position_speed.sv =====
// Top level of the encoder position and speed block.
// Usage:
//   Input channel (in_valid / in_stall / in_counter_reading) takes one reading of a
//   cleared 16-bit encoder counter per item. The front adds it to a saturating
//   32-bit pulse total in the accept cycle and queues the item.
//   Result channel (out_valid / out_stall / out_*) gives position in Q8 mm with a
//   half-millimetre offset, speed in Q8 mm/s and a saturation flag, one per item.
//   Configuration: cfg_we writes cfg_wdata to register cfg_index (0 pulses per mm,
//   1 sample period in ms); write only while the block is idle.
// Timing:
//   An accepted item waits in the queue; the back end pops it, scales it, divides
//   position, then speed, on the shared radix-4 divider and hands the result off.
//   The back end takes a new item only after it has handed off the last one.
//   The queue holds QUEUE_DEPTH items, so input is taken while the back end works.
// Reset: synchronous, active low; clears the pulse total, the queue, the result
//   valid flag and restores the configuration to 1 pulse/mm and 10 ms.
// Stall: a result holds on the outputs while out_stall is high; the back end
//   finishes the next item and waits, and in_stall rises once the queue is full.
`include "encoder_position_speed_defines.svh"

module encoder_position_speed #(
  parameter int QUEUE_DEPTH = eps_pkg::QUEUE_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [eps_pkg::READ_W-1:0]        in_counter_reading,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [eps_pkg::POS_W-1:0]  out_position_q8,
  output logic signed [eps_pkg::SPD_W-1:0]  out_speed_q8,
  output logic                              out_total_saturated,
  input  logic                              cfg_we,
  input  logic [eps_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [eps_pkg::CFG_W-1:0]         cfg_wdata
);

  eps_pkg::q_status_t q_status;
  eps_pkg::q_entry_t  q_wdata;
  eps_pkg::q_entry_t  q_rdata;
  logic               q_push;
  logic               q_pop;

  // Accept and classify readings
  eps_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_counter_reading (in_counter_reading),
    .q_status           (q_status),
    .q_push             (q_push),
    .q_wdata            (q_wdata)
  );

  // Decouple front and back
  eps_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk    (clk),
    .rst_n  (rst_n),
    .push   (q_push),
    .wdata  (q_wdata),
    .pop    (q_pop),
    .rdata  (q_rdata),
    .status (q_status)
  );

  // Divide and deliver results
  eps_back u_back (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .q_status            (q_status),
    .q_pop               (q_pop),
    .q_rdata             (q_rdata),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_position_q8     (out_position_q8),
    .out_speed_q8        (out_speed_q8),
    .out_total_saturated (out_total_saturated)
  );

  // Queue never underflows or overflows
  `EPS_ASSERT_NOW(a_pop_nonempty, q_pop, !q_status.empty)
  `EPS_ASSERT_NOW(a_push_notfull, q_push, !q_status.full)
  // Back end works on one item at a time
  `EPS_ASSERT_NEXT(a_pop_spaced, q_pop, !q_pop)
  // A stalled result is never dropped
  `EPS_ASSERT_NEXT(a_out_kept, out_valid && out_stall, out_valid)

endmodule

// ===== sim/encoder_position_speed_tb.sv =====
// Self-checking testbench for the encoder position and speed block.
`timescale 1ns / 1ps

module encoder_position_speed_tb;

  localparam int          SETTLE_CYCLES    = 100;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          WATCHDOG_LIMIT   = 4000;
  localparam int          PHASE_ITEMS      = 155;
  localparam int          MAX_SHOWN        = 10;
  localparam logic [15:0] READING_POS_MAX  = 16'h7FFF;
  localparam logic [15:0] READING_NEG_MAX  = 16'h8000;
  localparam longint      TOTAL_HI         = longint'(signed'(eps_pkg::TOTAL_MAX));
  localparam longint      TOTAL_LO         = longint'(signed'(eps_pkg::TOTAL_MIN));

  // Indexes that the block has no register for
  localparam logic [eps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [eps_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  localparam logic [eps_pkg::READ_W-1:0] DIRECTED_READINGS [16] = '{
    16'h0000, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h8001, 16'h7FFE,
    16'h5555, 16'hAAAA, 16'h00FF, 16'hFF00, 16'h0100, 16'hFFFE, 16'h8000, 16'h8000
  };

  typedef struct packed {
    logic signed [eps_pkg::POS_W-1:0] position_q8;
    logic signed [eps_pkg::SPD_W-1:0] speed_q8;
    logic                             total_saturated;
  } motion_t;

  logic                              clk = 1'b0;
  logic                              rst_n = 1'b0;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [eps_pkg::READ_W-1:0]        in_counter_reading = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic signed [eps_pkg::POS_W-1:0]  out_position_q8;
  logic signed [eps_pkg::SPD_W-1:0]  out_speed_q8;
  logic                              out_total_saturated;
  logic                              cfg_we = 1'b0;
  logic [eps_pkg::CFG_IDX_W-1:0]     cfg_index = '0;
  logic [eps_pkg::CFG_W-1:0]         cfg_wdata = '0;

  // Predictor state: pulse total and register copies
  int                                track_total = 0;
  logic [eps_pkg::CFG_W-1:0]         track_ppm = eps_pkg::PPM_RESET;
  logic [eps_pkg::CFG_W-1:0]         track_period = eps_pkg::PERIOD_RESET;

  logic [eps_pkg::READ_W-1:0]        reading_q[$];
  motion_t                           motion_expected_q[$];
  motion_t                           motion_want;
  int                                mismatch_cnt = 0;
  int unsigned                       send_idle_pct = 0;
  int unsigned                       recv_stall_pct = 0;
  logic                              long_hold_req = 1'b0;
  logic                              long_hold_done = 1'b0;
  int                                hold_left = 0;
  int                                quiet_cycles = 0;

  encoder_position_speed dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_counter_reading  (in_counter_reading),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_position_q8     (out_position_q8),
    .out_speed_q8        (out_speed_q8),
    .out_total_saturated (out_total_saturated),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Add one reading to the pulse total and compute position and speed
  function automatic motion_t advance_odometer(logic [eps_pkg::READ_W-1:0] raw);
    motion_t m;
    longint  delta;
    longint  sum;
    longint  ppm;
    longint  per;
    longint  pos;
    longint  spd;
    delta = longint'(signed'(raw));
    sum = longint'(track_total) + delta;
    m.total_saturated = 1'b0;
    if (sum > TOTAL_HI) begin
      sum = TOTAL_HI;
      m.total_saturated = 1'b1;
    end else if (sum < TOTAL_LO) begin
      sum = TOTAL_LO;
      m.total_saturated = 1'b1;
    end
    track_total = int'(sum);
    ppm = (track_ppm == '0) ? 64'sd1 : longint'(track_ppm);
    per = (track_period == '0) ? 64'sd1 : longint'(track_period);
    // Integer division truncates toward zero
    pos = (sum * (64'sd1 << eps_pkg::Q8_SHIFT)) / ppm + longint'(eps_pkg::POS_OFFSET);
    spd = (delta * longint'(eps_pkg::SPD_SCALE)) / (ppm * per);
    m.position_q8 = pos[eps_pkg::POS_W-1:0];
    m.speed_q8 = spd[eps_pkg::SPD_W-1:0];
    return m;
  endfunction

  // Mix full-range readings with small deltas and values near the limits
  function automatic logic [eps_pkg::READ_W-1:0] pick_reading();
    int unsigned                sel;
    logic [eps_pkg::READ_W-1:0] r;
    sel = $urandom_range(9);
    r = eps_pkg::READ_W'($urandom);
    if (sel >= 5 && sel <= 7) begin
      r = eps_pkg::READ_W'($urandom_range(512)) - 16'd256;
    end else if (sel == 8) begin
      case ($urandom_range(4))
        0: r = READING_POS_MAX;
        1: r = READING_NEG_MAX;
        2: r = 16'hFFFF;
        3: r = 16'h0001;
        default: r = 16'h0000;
      endcase
    end else if (sel == 9) begin
      r = r[15] ? READING_NEG_MAX + eps_pkg::READ_W'($urandom_range(255))
                : READING_POS_MAX - eps_pkg::READ_W'($urandom_range(255));
    end
    return r;
  endfunction

  task automatic compare_field(string name, longint want, longint got);
    if (want != got) begin
      mismatch_cnt++;
      if (mismatch_cnt <= MAX_SHOWN)
        $display("mismatch on %s: expected %0d, got %0d", name, want, got);
    end
  endtask

  // Driver: offer queued readings, predict each accepted one
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall)
        motion_expected_q.push_back(advance_odometer(in_counter_reading));
      if (!in_valid || !in_stall) begin
        if (reading_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_counter_reading <= reading_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result, drive random and long stalls
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (motion_expected_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_SHOWN)
            $display("unexpected result: position %0d, speed %0d, saturated %0b",
                     out_position_q8, out_speed_q8, out_total_saturated);
        end else begin
          motion_want = motion_expected_q.pop_front();
          compare_field("position_q8", motion_want.position_q8, out_position_q8);
          compare_field("speed_q8", motion_want.speed_q8, out_speed_q8);
          compare_field("total_saturated", motion_want.total_saturated,
                        out_total_saturated);
        end
      end
      if (long_hold_req && !long_hold_done) begin
        long_hold_done <= 1'b1;
        hold_left <= LONG_HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("encoder_position_speed_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(logic [eps_pkg::CFG_IDX_W-1:0] idx,
                           logic [eps_pkg::CFG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == eps_pkg::CFG_IDX_PPM)
      track_ppm = data;
    else if (idx == eps_pkg::CFG_IDX_PERIOD)
      track_period = data;
  endtask

  // Hold until every reading is taken and every result has come, then settle
  task automatic wait_idle();
    while (reading_q.size() != 0 || in_valid || motion_expected_q.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_phase(logic [eps_pkg::CFG_W-1:0] ppm, logic [eps_pkg::CFG_W-1:0] per,
                           int unsigned send_pct, int unsigned stall_pct,
                           logic with_spare, logic with_hold);
    write_reg(eps_pkg::CFG_IDX_PPM, ppm);
    write_reg(eps_pkg::CFG_IDX_PERIOD, per);
    if (with_spare) begin
      write_reg(CFG_IDX_SPARE_LO, eps_pkg::CFG_W'($urandom));
      write_reg(CFG_IDX_SPARE_HI, eps_pkg::CFG_W'($urandom));
    end
    @(posedge clk);
    send_idle_pct <= send_pct;
    recv_stall_pct <= stall_pct;
    if (with_hold)
      long_hold_req <= 1'b1;
    repeat (PHASE_ITEMS) reading_q.push_back(pick_reading());
    wait_idle();
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Field extremes and sign boundaries under the reset settings
    foreach (DIRECTED_READINGS[i])
      reading_q.push_back(DIRECTED_READINGS[i]);
    wait_idle();

    // Random readings across register settings and idle patterns
    run_phase(16'd1, 16'd1, 0, 0, 1'b0, 1'b1);
    run_phase(16'hFFFF, 16'hFFFF, 69, 0, 1'b0, 1'b0);
    run_phase(16'd0, 16'd0, 0, 69, 1'b1, 1'b0);
    run_phase(eps_pkg::CFG_W'($urandom_range(1, 65535)),
              eps_pkg::CFG_W'($urandom_range(1, 20)), 37, 37, 1'b0, 1'b0);
    run_phase(16'd1, 16'hFFFF, 69, 0, 1'b0, 1'b0);
    run_phase(16'hFFFF, 16'd1, 0, 69, 1'b0, 1'b0);
    run_phase(eps_pkg::CFG_W'($urandom_range(1, 40)),
              eps_pkg::CFG_W'($urandom_range(1, 40)), 37, 37, 1'b1, 1'b0);
    run_phase(16'd3, 16'd1000, 0, 0, 1'b0, 1'b0);

    if (mismatch_cnt == 0 && motion_expected_q.size() == 0)
      $display("encoder_position_speed_tb: done, clean");
    else
      $display("encoder_position_speed_tb: done, errors");
    $finish;
  end

endmodule

// ===== encoder_position_speed.f =====
+incdir+rtl/core
rtl/core/eps_pkg.sv
rtl/core/eps_front.sv
rtl/core/eps_fifo.sv
rtl/core/eps_back.sv
rtl/core/encoder_position_speed.sv
sim/encoder_position_speed_tb.sv
